/* rtl/twsc_pkg.sv */
// Shared types, constants and codes for the tilt/weight sip classifier.
`default_nettype none
package twsc_pkg;

  // Input modes
  localparam logic [1:0] MODE_POLL     = 2'd0;
  localparam logic [1:0] MODE_DAY_CLR  = 2'd1;
  localparam logic [1:0] MODE_BASELINE = 2'd2;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_COS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIP_DELTA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GULP_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_LIMIT = 3'd4;

  // Register reset values
  localparam logic signed [15:0] TILT_COS_RST     = 16'sd23170;
  localparam logic [15:0]        MIN_INTERVAL_RST = 16'd2000;
  localparam logic [15:0]        SIP_DELTA_RST    = 16'd50;
  localparam logic [15:0]        GULP_LIMIT_RST   = 16'd500;
  localparam logic [15:0]        REFILL_LIMIT_RST = 16'd50;

  // Below this squared magnitude (164^2 counts) the sample is never counted as tilted
  localparam logic [31:0] MAG2_MIN = 32'd26896;

  // Decoupling queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SIP    = 2'd1,
    EV_GULP   = 2'd2,
    EV_REFILL = 2'd3
  } event_t;

  typedef struct packed {
    logic signed [15:0] tilt_cos_limit;
    logic [15:0]        min_interval_ms;
    logic [15:0]        sip_delta_min;
    logic [15:0]        gulp_limit;
    logic [15:0]        refill_limit;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0]         mode;
    logic               tilted;
    logic signed [23:0] weight;
    logic [31:0]        time_ms;
  } item_t;

endpackage
`default_nettype wire

/* rtl/tilt_weight_sip_classifier_top.sv */
// Top level of the tilt/weight sip classifier: config registers and glue.
`default_nettype none
//
//  channel   handshake        payload
//  -------   --------------   -----------------------------------------------
//  input     push / full      mode, accel_x/y/z, weight_dg, time_ms
//  result    empty / pop      event_res, amount_dg, daily_intake, sip_total
//  config    cfg_we           cfg_index, cfg_data (16 bit, no read-back)
//
//  In the front end a sample goes through the squares on acceptance, then
//  magnitude sum, two split c^2*m2 partial products, and the tilt compare.
//  The back end retires one transaction a cycle unless the result register
//  waits on pop; a two-entry queue lets the front keep working meanwhile.
//  Reset (rst, synchronous) clears all daily state and loads default config.
//  full is high whenever the front sequencer is busy; a full queue holds it busy.
//
module tilt_weight_sip_classifier_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              push,
  output logic                             full,
  input  wire  [1:0]                       mode,
  input  wire  signed [15:0]               accel_x,
  input  wire  signed [15:0]               accel_y,
  input  wire  signed [15:0]               accel_z,
  input  wire  signed [23:0]               weight_dg,
  input  wire  [31:0]                      time_ms,
  output logic                             empty,
  input  wire                              pop,
  output logic [1:0]                       event_res,
  output logic [23:0]                      amount_dg,
  output logic [31:0]                      daily_intake,
  output logic [7:0]                       sip_total,
  input  wire                              cfg_we,
  input  wire  [twsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [15:0]                      cfg_data
);
  import twsc_pkg::*;

  cfg_t  cfg;
  item_t f_item, q_rd_item;
  logic  f_push, q_full, q_empty, q_pop;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tilt_cos_limit  <= TILT_COS_RST;
      cfg.min_interval_ms <= MIN_INTERVAL_RST;
      cfg.sip_delta_min   <= SIP_DELTA_RST;
      cfg.gulp_limit      <= GULP_LIMIT_RST;
      cfg.refill_limit    <= REFILL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILT_COS:     cfg.tilt_cos_limit  <= $signed(cfg_data);
        CFG_MIN_INTERVAL: cfg.min_interval_ms <= cfg_data;
        CFG_SIP_DELTA:    cfg.sip_delta_min   <= cfg_data;
        CFG_GULP_LIMIT:   cfg.gulp_limit      <= cfg_data;
        CFG_REFILL_LIMIT: cfg.refill_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  twsc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .weight_dg      (weight_dg),
    .time_ms        (time_ms),
    .tilt_cos_limit (cfg.tilt_cos_limit),
    .q_push         (f_push),
    .q_full         (q_full),
    .q_item         (f_item)
  );

  twsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rd_item (q_rd_item)
  );

  twsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .amount_dg    (amount_dg),
    .daily_intake (daily_intake),
    .sip_total    (sip_total)
  );

endmodule
`default_nettype wire

/* rtl/twsc_front.sv */
// Front end: accepts samples and runs the tilt test over a short sequence.
`default_nettype none
module twsc_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire  [1:0]           mode,
  input  wire  signed [15:0]   accel_x,
  input  wire  signed [15:0]   accel_y,
  input  wire  signed [15:0]   accel_z,
  input  wire  signed [23:0]   weight_dg,
  input  wire  [31:0]          time_ms,
  input  wire  signed [15:0]   tilt_cos_limit,
  output logic                 q_push,
  input  wire                  q_full,
  output twsc_pkg::item_t      q_item
);
  import twsc_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SUM  = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;

  logic signed [31:0] px, py, pz, pc;
  logic [30:0] sq_x, sq_y, sq_z, c2;
  logic        c_neg, z_pos, z_neg;
  logic [1:0]         mode_r;
  logic signed [23:0] weight_r;
  logic [31:0]        time_r;
  logic [31:0] m2;
  logic [46:0] pp_lo, pp_hi;
  logic [62:0] c2m, z2s;
  logic        tilted;
  logic        accept;

  assign full   = (state != F_IDLE);
  assign accept = push && !full;

  assign px = 32'(accel_x) * 32'(accel_x);
  assign py = 32'(accel_y) * 32'(accel_y);
  assign pz = 32'(accel_z) * 32'(accel_z);
  assign pc = 32'(tilt_cos_limit) * 32'(tilt_cos_limit);

  // Sign-aware compare of z*2^15 against c*|a| through squares
  assign c2m = {pp_hi, 16'b0} + {16'b0, pp_lo};
  assign z2s = {2'b0, sq_z, 30'b0};
  always_comb begin
    if (m2 < MAG2_MIN) begin
      tilted = 1'b0;
    end else if (!c_neg) begin
      tilted = !z_pos || (z2s <= c2m);
    end else begin
      tilted = z_neg && (z2s >= c2m);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_x     <= px[30:0];
      sq_y     <= py[30:0];
      sq_z     <= pz[30:0];
      c2       <= pc[30:0];
      c_neg    <= tilt_cos_limit[15];
      z_neg    <= accel_z[15];
      z_pos    <= !accel_z[15] && (accel_z != 16'sd0);
      mode_r   <= mode;
      weight_r <= weight_dg;
      time_r   <= time_ms;
    end
    if (state == F_SUM) begin
      m2 <= {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
    end
    if (state == F_MUL) begin
      pp_lo <= 47'(c2) * 47'(m2[15:0]);
      pp_hi <= 47'(c2) * 47'(m2[31:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_SUM;
        F_SUM:  state <= F_MUL;
        F_MUL:  state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  assign q_push        = (state == F_PUSH) && !q_full;
  assign q_item.mode    = mode_r;
  assign q_item.tilted  = tilted;
  assign q_item.weight  = weight_r;
  assign q_item.time_ms = time_r;

endmodule
`default_nettype wire

/* rtl/twsc_queue.sv */
// Short register queue between front and back ends.
`default_nettype none
module twsc_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr,
  input  twsc_pkg::item_t  wr_item,
  output logic             q_full,
  input  wire              rd,
  output logic             q_empty,
  output twsc_pkg::item_t  rd_item
);
  import twsc_pkg::*;

  item_t slots [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;
  logic do_wr, do_rd;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == QAW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == QAW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/twsc_back.sv */
// Back end: daily state update, event decision and result register.
`default_nettype none
module twsc_back (
  input  wire              clk,
  input  wire              rst,
  input  twsc_pkg::cfg_t   cfg,
  input  wire              q_empty,
  input  twsc_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             empty,
  input  wire              pop,
  output logic [1:0]       event_res,
  output logic [23:0]      amount_dg,
  output logic [31:0]      daily_intake,
  output logic [7:0]       sip_total
);
  import twsc_pkg::*;

  logic signed [23:0] last_weight;
  logic [31:0]        last_sip_time;
  logic [31:0]        intake_sum;
  logic [7:0]         sip_counter;

  logic               out_valid;
  event_t             ev_r;
  logic [23:0]        amount_r;
  logic [31:0]        intake_r;
  logic [7:0]         count_r;

  logic signed [24:0] delta, neg_delta;
  logic [31:0]        since;
  logic [32:0]        sum;
  logic               gate, is_sip, is_refill, take;
  logic [31:0]        intake_next;
  logic [7:0]         counter_next;
  event_t             ev_next;

  assign take  = !q_empty && (!out_valid || pop);
  assign q_pop = take;

  assign delta     = $signed({last_weight[23], last_weight})
                   - $signed({q_item.weight[23], q_item.weight});
  assign neg_delta = -delta;
  assign since     = q_item.time_ms - last_sip_time;
  assign sum       = {1'b0, intake_sum} + {9'b0, delta[23:0]};

  assign gate      = q_item.tilted && !q_item.weight[23]
                   && (since >= {16'b0, cfg.min_interval_ms});
  assign is_sip    = gate && (delta >= $signed({9'b0, cfg.sip_delta_min}));
  assign is_refill = gate && !is_sip
                   && (neg_delta > $signed({9'b0, cfg.refill_limit}));

  always_comb begin
    intake_next  = intake_sum;
    counter_next = sip_counter;
    ev_next      = EV_NONE;
    unique case (q_item.mode)
      MODE_DAY_CLR: begin
        intake_next  = '0;
        counter_next = '0;
      end
      MODE_POLL: begin
        if (is_sip) begin
          intake_next  = sum[32] ? '1 : sum[31:0];
          counter_next = sip_counter + 8'd1;
          ev_next      = (delta > $signed({9'b0, cfg.gulp_limit})) ? EV_GULP : EV_SIP;
        end else if (is_refill) begin
          ev_next = EV_REFILL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_weight   <= '0;
      last_sip_time <= '0;
      intake_sum    <= '0;
      sip_counter   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        intake_sum  <= intake_next;
        sip_counter <= counter_next;
        if (q_item.mode == MODE_BASELINE) last_weight <= q_item.weight;
        if (q_item.mode == MODE_POLL && (is_sip || is_refill)) begin
          last_weight <= q_item.weight;
        end
        if (q_item.mode == MODE_POLL && is_sip) last_sip_time <= q_item.time_ms;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r     <= ev_next;
      amount_r <= (ev_next == EV_SIP || ev_next == EV_GULP) ? delta[23:0] : '0;
      intake_r <= intake_next;
      count_r  <= counter_next;
    end
  end

  assign empty        = !out_valid;
  assign event_res    = ev_r;
  assign amount_dg    = amount_r;
  assign daily_intake = intake_r;
  assign sip_total    = count_r;

endmodule
`default_nettype wire
